>>> rtl/core/mr_pkg.sv
`default_nettype none

package mr_pkg;

   // Sequencer of one round, in the top level.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASSIFY,
      S_SPLIT,
      S_REDUCE,
      S_WITNESS,
      S_POW_CHECK,
      S_POW_MUL,
      S_POW_SQR,
      S_TEST,
      S_SQ_CHECK,
      S_SQ_MUL,
      S_FINISH
   } mr_state_type;

   // Phases of the bit-serial modular multiplier.
   typedef enum logic [1:0] {
      MM_IDLE,
      MM_DOUBLE,
      MM_ADD
   } mm_state_type;

endpackage

`default_nettype wire

>>> rtl/core/mr_modmul.sv
`default_nettype none

// Bit-serial modular multiplier: product = op_a * op_b mod modulus, for operands
// below the modulus. One bit of op_b is taken per doubling and addition step, MSB first.
module mr_modmul import mr_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic [WIDTH-1:0] modulus,
   output logic                  done,
   output logic      [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);

   mm_state_type     state_ff, state_in;
   logic [WIDTH-1:0] a_ff, b_ff, n_ff, acc_ff;
   logic [CW-1:0]    cnt_ff;
   logic             done_ff;

   logic [WIDTH-1:0] add_y;
   logic [WIDTH:0]   sum;
   logic [WIDTH+1:0] diff;
   logic [WIDTH-1:0] add_res;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MM_IDLE:   if (start) state_in = MM_DOUBLE;
         MM_DOUBLE: state_in = MM_ADD;
         MM_ADD:    state_in = (cnt_ff == '0) ? MM_IDLE : MM_DOUBLE;
         default:   state_in = MM_IDLE;
      endcase
   end

   // Modular addition of the accumulator and either itself or the selected addend.
   always_comb begin
      unique case (state_ff)
         MM_DOUBLE: add_y = acc_ff;
         MM_ADD:    add_y = b_ff[WIDTH-1] ? a_ff : '0;
         default:   add_y = '0;
      endcase
      sum     = {1'b0, acc_ff} + {1'b0, add_y};
      diff    = {1'b0, sum} - {2'b00, n_ff};
      add_res = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MM_ADD) && (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         MM_IDLE: begin
            if (start) begin
               a_ff   <= op_a;
               b_ff   <= op_b;
               n_ff   <= modulus;
               acc_ff <= '0;
               cnt_ff <= CW'(WIDTH - 1);
            end
         end
         MM_DOUBLE: acc_ff <= add_res;
         MM_ADD: begin
            acc_ff <= add_res;
            b_ff   <= {b_ff[WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

>>> rtl/core/miller_rabin_round.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   req_candidate, req_random_value
// rsp      out        rsp_valid / rsp_ready   rsp_probably_prime, rsp_trivial,
//                                             rsp_witness_used
//
// One item is worked at a time. A full round makes at most 2*WIDTH - s - 1 modular
// multiplications, each run by the bit-serial multiplier.
// Reset is synchronous and active high; it empties the result register and idles the sequencer.
// A transfer is taken while a result waits; a round stalls only at its end, until that is free.
module miller_rabin_round import mr_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_candidate,
   input  wire logic [31:0] req_random_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_probably_prime,
   output logic             rsp_trivial,
   output logic [31:0]      rsp_witness_used
);

   localparam int CW = $clog2(WIDTH);

   mr_state_type     state_ff, state_in;

   // Working registers of the round.
   logic [WIDTH-1:0] n_ff;      // candidate
   logic [WIDTH-1:0] nm1_ff;    // candidate minus one
   logic [WIDTH-1:0] m_ff;      // candidate minus three, divisor in the witness reduction
   logic [WIDTH-1:0] r_ff;      // random value, shifted out MSB first
   logic [WIDTH-1:0] rem_ff;    // running remainder of the reduction
   logic [WIDTH-1:0] d_ff;      // odd part of n-1, then the exponent shifted down
   logic [CW-1:0]    s_ff;      // power of two in n-1
   logic [CW-1:0]    k_ff;      // squarings done so far, plus one
   logic [CW-1:0]    cnt_ff;    // bit counter of the reduction
   logic [WIDTH-1:0] a_ff;      // witness
   logic [WIDTH-1:0] base_ff;   // running square of the witness
   logic [WIDTH-1:0] acc_ff;    // power accumulator, later x
   logic             pass_ff;
   logic             trivial_ff;

   // Output register.
   logic             rsp_valid_ff;
   logic             rsp_prime_ff;
   logic             rsp_trivial_ff;
   logic [31:0]      rsp_witness_ff;

   // Multiplier connection.
   logic             mul_start;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic             mul_done;
   logic [WIDTH-1:0] mul_prod;

   logic             n_trivial, n_prime, rsp_free;
   logic [WIDTH:0]   red_t;
   logic [WIDTH+1:0] red_diff;
   logic [WIDTH-1:0] rem_next;

   mr_modmul #(
      .WIDTH(WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (n_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Zero, one and even numbers are composite, two and three are prime, all
   // without a round.
   assign n_prime   = (n_ff[WIDTH-1:2] == '0) && n_ff[1];
   assign n_trivial = (n_ff[WIDTH-1:2] == '0) || !n_ff[0];
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // One restoring step of random_value mod (n-3): bring in the next bit and
   // subtract the divisor once if the partial remainder reaches it.
   always_comb begin
      red_t    = {rem_ff, r_ff[WIDTH-1]};
      red_diff = {1'b0, red_t} - {2'b00, m_ff};
      rem_next = red_diff[WIDTH+1] ? red_t[WIDTH-1:0] : red_diff[WIDTH-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_CLASSIFY;
         S_CLASSIFY:  state_in = n_trivial ? S_FINISH : S_SPLIT;
         S_SPLIT:     if (d_ff[0]) state_in = S_REDUCE;
         S_REDUCE:    if (cnt_ff == '0) state_in = S_WITNESS;
         S_WITNESS:   state_in = S_POW_CHECK;
         S_POW_CHECK: begin
            priority if (d_ff == '0) state_in = S_TEST;
            else if (d_ff[0])        state_in = S_POW_MUL;
            else                     state_in = S_POW_SQR;
         end
         S_POW_MUL:   if (mul_done) state_in = S_POW_SQR;
         S_POW_SQR:   if (mul_done) state_in = S_POW_CHECK;
         S_TEST:      state_in = S_SQ_CHECK;
         S_SQ_CHECK:  state_in = (pass_ff || (k_ff >= s_ff)) ? S_FINISH : S_SQ_MUL;
         S_SQ_MUL:    if (mul_done) state_in = S_SQ_CHECK;
         S_FINISH:    if (rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // The multiplier is started on the way into each of its waiting states.
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      mul_a     = base_ff;
      mul_b     = base_ff;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_POW_CHECK: begin
            if (d_ff != '0) begin
               mul_start = 1'b1;
               if (d_ff[0]) mul_a = acc_ff;
            end
         end
         S_POW_MUL: mul_start = mul_done;
         S_SQ_CHECK: begin
            mul_start = !(pass_ff || (k_ff >= s_ff));
            mul_a     = acc_ff;
            mul_b     = acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            n_ff <= WIDTH'(req_candidate);
            r_ff <= WIDTH'(req_random_value);
         end
         S_CLASSIFY: begin
            nm1_ff     <= n_ff - 1'b1;
            m_ff       <= n_ff - WIDTH'(3);
            d_ff       <= n_ff - 1'b1;
            s_ff       <= '0;
            rem_ff     <= '0;
            cnt_ff     <= CW'(WIDTH - 1);
            pass_ff    <= n_prime;
            trivial_ff <= n_trivial;
            a_ff       <= '0;
         end
         S_SPLIT: begin
            if (!d_ff[0]) begin
               d_ff <= d_ff >> 1;
               s_ff <= s_ff + 1'b1;
            end
         end
         S_REDUCE: begin
            rem_ff <= rem_next;
            r_ff   <= {r_ff[WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         S_WITNESS: begin
            a_ff    <= rem_ff + WIDTH'(2);
            base_ff <= rem_ff + WIDTH'(2);
            acc_ff  <= WIDTH'(1);
         end
         S_POW_MUL: if (mul_done) acc_ff <= mul_prod;
         S_POW_SQR: begin
            if (mul_done) begin
               base_ff <= mul_prod;
               d_ff    <= d_ff >> 1;
            end
         end
         S_TEST: begin
            pass_ff <= (acc_ff == WIDTH'(1)) || (acc_ff == nm1_ff);
            k_ff    <= CW'(1);
         end
         S_SQ_MUL: begin
            if (mul_done) begin
               acc_ff  <= mul_prod;
               pass_ff <= (mul_prod == nm1_ff);
               k_ff    <= k_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_prime_ff   <= pass_ff;
               rsp_trivial_ff <= trivial_ff;
               rsp_witness_ff <= 32'(a_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probably_prime = rsp_prime_ff;
   assign rsp_trivial        = rsp_trivial_ff;
   assign rsp_witness_used   = rsp_witness_ff;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

// Self-checking bench for one Miller-Rabin round. A queue of test cases, filled
// by the stimulus process, feeds a clocked driver on the request channel. Every
// transfer that the block takes is run through a bit-true model of the round
// here in the bench, and the verdict it gives waits in a queue until the
// clocked monitor on the response channel takes the matching transfer and
// compares the three fields.
module tb_top;

   // A correct run of all 121 items, with every stall and every gap, stays well
   // under this limit, so the limit only trips on a hang.
   localparam int CYCLE_LIMIT = 4_000_000;

   // Once this few items remain to be taken, both sides stop idling.
   localparam int CALM_TAIL = 15;

   typedef struct {
      logic [31:0] cand;
      logic [31:0] raw;
   } test_case_type;

   typedef struct {
      logic [31:0] cand;
      logic        prime;
      logic        trivial;
      logic [31:0] witness;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_candidate = '0;
   logic [31:0] req_random_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_probably_prime;
   logic        rsp_trivial;
   logic [31:0] rsp_witness_used;

   test_case_type cases_to_send[$];
   verdict_type   verdicts_due[$];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  items_total    = 32'h3fff_ffff;
   int  error_count    = 0;
   int  cycle_count    = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   bit  calm           = 1'b0;

   test_case_type next_case;
   verdict_type   due;

   miller_rabin_round DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_candidate      (req_candidate),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_probably_prime (rsp_probably_prime),
      .rsp_trivial        (rsp_trivial),
      .rsp_witness_used   (rsp_witness_used)
   );

   always #5 clock = ~clock;

   // Products of two 32-bit residues fit in 64 bits, so the
   // reduction can be done in one step rather than bit by bit.
   function automatic logic [31:0] mod_product(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] n);
      logic [63:0] wide;
      wide = {32'd0, a} * {32'd0, b};
      wide = wide % {32'd0, n};
      return wide[31:0];
   endfunction

   // Square-and-multiply, least significant exponent bit first.
   function automatic logic [31:0] mod_power(input logic [31:0] base, input logic [31:0] e,
                                             input logic [31:0] n);
      logic [31:0] acc;
      logic [31:0] sq;
      logic [31:0] rest;
      acc  = 32'd1;
      sq   = base % n;
      rest = e;
      while (rest != 32'd0) begin
         if (rest[0]) acc = mod_product(acc, sq, n);
         sq   = mod_product(sq, sq, n);
         rest = rest >> 1;
      end
      return acc;
   endfunction

   // The verdict of one round. Candidates below four and even candidates are
   // settled at once; every other candidate gets a witness between 2 and n-2.
   function automatic verdict_type predict_verdict(input logic [31:0] n,
                                                   input logic [31:0] raw);
      verdict_type v;
      logic [31:0] n_minus_1;
      logic [31:0] odd_part;
      logic [31:0] x;
      int          twos;
      logic        pass;
      v.cand    = n;
      v.prime   = 1'b0;
      v.trivial = 1'b1;
      v.witness = '0;
      if (n < 32'd4 || !n[0]) begin
         v.prime = (n == 32'd2 || n == 32'd3);
         return v;
      end
      n_minus_1 = n - 32'd1;
      odd_part  = n_minus_1;
      twos      = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      v.witness = (raw % (n - 32'd3)) + 32'd2;
      x    = mod_power(v.witness, odd_part, n);
      pass = (x == 32'd1 || x == n_minus_1);
      for (int k = 1; !pass && k < twos; k++) begin
         x = mod_product(x, x, n);
         if (x == n_minus_1) pass = 1'b1;
      end
      v.trivial = 1'b0;
      v.prime   = pass;
      return v;
   endfunction

   // A handful of large and middling primes, so that the random part sees
   // plenty of passing rounds and not only composites.
   function automatic logic [31:0] known_prime(input int k);
      case (k)
         0:       return 32'd4294967291;
         1:       return 32'd4294967279;
         2:       return 32'd2147483647;
         3:       return 32'd1000000007;
         4:       return 32'd998244353;
         5:       return 32'd65537;
         6:       return 32'd65521;
         default: return 32'd3221225473;
      endcase
   endfunction

   task automatic queue_case(input logic [31:0] cand, input logic [31:0] raw);
      test_case_type tc;
      tc.cand = cand;
      tc.raw  = raw;
      cases_to_send.push_back(tc);
      queued_count++;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] cand,
                                  input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: candidate %0d, got %0d, expected %0d", what, cand, got, want);
      error_count++;
   endtask

   // Request driver. The payload is only changed when the slot is free, that
   // is when nothing is on offer or the offer has just been taken, so valid and
   // the payload hold steady until each transfer completes. After a transfer a
   // random burst of idle cycles may follow.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            verdicts_due.push_back(predict_verdict(req_candidate, req_random_value));
            accepted_count++;
            calm = (accepted_count + CALM_TAIL >= items_total);
            if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 19);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cases_to_send.size() > 0) begin
               next_case = cases_to_send.pop_front();
               req_valid        <= 1'b1;
               req_candidate    <= next_case.cand;
               req_random_value <= next_case.raw;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each response transfer is matched with the oldest
   // outstanding verdict. Ready drops in random bursts except near the end.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch("response with nothing outstanding", 32'd0,
                               {31'd0, rsp_probably_prime}, 32'd0);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_probably_prime !== due.prime)
                  report_mismatch("probably_prime", due.cand, {31'd0, rsp_probably_prime},
                                  {31'd0, due.prime});
               if (rsp_trivial !== due.trivial)
                  report_mismatch("trivial", due.cand, {31'd0, rsp_trivial},
                                  {31'd0, due.trivial});
               if (rsp_witness_used !== due.witness)
                  report_mismatch("witness_used", due.cand, rsp_witness_used, due.witness);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int          sel;
      logic [31:0] cand;
      logic [31:0] raw;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the trivially decided candidates (zero, one, two,
      // three and even numbers up to the top of the range), the smallest
      // candidate that gets a real round, where the witness is two or three,
      // then known composites, strong pseudoprimes that fool the base-two
      // witness, a Carmichael number, a candidate whose n-1 holds thirty-one
      // factors of two, and the largest 32-bit prime, with extreme raw values.
      queue_case(32'd0, 32'd0);
      queue_case(32'd1, 32'hffff_ffff);
      queue_case(32'd2, 32'd12345);
      queue_case(32'd3, 32'hffff_ffff);
      queue_case(32'd4, 32'd0);
      queue_case(32'hffff_fffe, 32'haaaa_aaaa);
      queue_case(32'h8000_0000, 32'd1);
      queue_case(32'd5, 32'd0);
      queue_case(32'd5, 32'hffff_ffff);
      queue_case(32'd7, 32'd3);
      queue_case(32'd9, 32'd0);
      queue_case(32'd2047, 32'd0);
      queue_case(32'd561, 32'h5555_5555);
      queue_case(32'd25326001, 32'd0);
      queue_case(32'd3215031751, 32'd0);
      queue_case(32'd65537, 32'hdead_beef);
      queue_case(32'd2147483647, 32'hffff_ffff);
      queue_case(32'd4294967291, 32'd0);
      queue_case(32'd4294967291, 32'hffff_ffff);
      queue_case(32'hffff_ffff, 32'h1234_5678);
      queue_case(32'h8000_0001, 32'h7fff_ffff);

      // Hold the sender back until the directed items have all come back, so
      // that the block is seen starting again from a drained pipeline.
      while (accepted_count < queued_count || verdicts_due.size() > 0) @(posedge clock);

      // Random part: mostly odd candidates that get a full round, with a
      // share of known primes and small odd numbers so that passing rounds
      // are common, and some trivially decided ones in between.
      for (int i = 0; i < 100; i++) begin
         sel = $urandom_range(0, 19);
         raw = $urandom;
         if ($urandom_range(0, 9) == 0) raw = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
         if (sel < 2) begin
            cand = $urandom_range(0, 3);
         end else if (sel < 4) begin
            cand = $urandom & ~32'd1;
         end else if (sel < 7) begin
            cand = $urandom_range(5, 4095) | 32'd1;
         end else if (sel < 9) begin
            cand = known_prime($urandom_range(0, 7));
         end else begin
            cand = $urandom | 32'd1;
            if (cand < 32'd5) cand = 32'd5;
         end
         queue_case(cand, raw);
      end
      items_total = queued_count;

      while (accepted_count < items_total || verdicts_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
